// ===== src/quoted_command_tokenizer_defines.svh =====
// assertion macros for the command tokenizer
`ifndef QUOTED_COMMAND_TOKENIZER_DEFINES_SVH
`define QUOTED_COMMAND_TOKENIZER_DEFINES_SVH

`ifndef ASSERT_OFF

// condition holds in the same cycle as the trigger
`define QCT_ASSERT_IMPL(lbl, clk, rst_n, pre, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (con)) \
    else $error("assertion failed");

// condition holds in the cycle after the trigger
`define QCT_ASSERT_NEXT(lbl, clk, rst_n, pre, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (con)) \
    else $error("assertion failed");

`else

`define QCT_ASSERT_IMPL(lbl, clk, rst_n, pre, con)
`define QCT_ASSERT_NEXT(lbl, clk, rst_n, pre, con)

`endif

`endif

// ===== src/qct_pkg.sv =====
// shared types and constants of the command tokenizer
package qct_pkg;

  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_SEMI    = 8'h3B;

  localparam int QUEUE_DEPTH    = 4;
  localparam int QUEUE_PTR_BITS = 2;
  localparam int QUEUE_CNT_BITS = 3;

  localparam logic KIND_ARG     = 1'b0;
  localparam logic KIND_CMD_END = 1'b1;

  typedef struct packed {
    logic        arg_v;
    logic        cmd_v;
    logic        ovf;
    logic [15:0] offset;
    logic [15:0] length;
  } entry_t;

endpackage

// ===== src/qct_front.sv =====
// front end: character classification, tokenizer state and record building
module qct_front #(
  parameter int POSITION_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic              q_full,
  input  logic [7:0]        char_code,
  input  logic              end_of_text,
  output logic              ent_push,
  output qct_pkg::entry_t   ent
);

  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic [POSITION_BITS-1:0] start_r, start_nxt;
  logic                     ina_r, ina_nxt;
  logic                     inq_r, inq_nxt;
  logic                     has_r, has_nxt;
  logic                     ovf_r, ovf_nxt;

  logic                     accept;
  logic [7:0]               c;
  logic                     is_sep, is_cmd_end, is_quote, is_nul;
  logic                     pos_last;
  logic [POSITION_BITS-1:0] pos_inc;
  logic [POSITION_BITS-1:0] len;
  logic                     close, arg_v, has_after, cmd_trig, cmd_v;
  logic [POSITION_BITS+15:0] start_ext, len_ext;

  assign accept = push && !q_full;

  always_comb begin
    c          = end_of_text ? qct_pkg::CH_NUL : char_code;
    is_sep     = c inside {qct_pkg::CH_SPACE, qct_pkg::CH_NUL};
    is_cmd_end = c inside {qct_pkg::CH_SEMI, qct_pkg::CH_NEWLINE};
    is_quote   = (c == qct_pkg::CH_QUOTE);
    is_nul     = (c == qct_pkg::CH_NUL);
    pos_last   = &pos_r;
    pos_inc    = pos_last ? pos_r : pos_r + 1'b1;
    len        = (pos_r >= start_r) ? pos_r - start_r : '0;

    close     = ina_r && ((!inq_r && (is_sep || is_cmd_end)) ||
                          (inq_r && (is_quote || is_nul)));
    arg_v     = close && (len != '0);
    has_after = has_r || arg_v;
    cmd_trig  = (is_cmd_end && !(ina_r && inq_r)) || end_of_text;
    cmd_v     = cmd_trig && has_after;

    ina_nxt   = ina_r;
    inq_nxt   = inq_r;
    start_nxt = start_r;
    if (!ina_r) begin
      if (!is_sep && !is_cmd_end) begin
        ina_nxt   = 1'b1;
        inq_nxt   = is_quote;
        start_nxt = is_quote ? pos_inc : pos_r;
      end
    end else if (!inq_r && is_quote) begin
      inq_nxt   = 1'b1;
      start_nxt = pos_inc;
    end
    if (close) begin
      ina_nxt = 1'b0;
      inq_nxt = 1'b0;
    end
    has_nxt = cmd_trig ? 1'b0 : has_after;
    pos_nxt = pos_inc;
    ovf_nxt = ovf_r || pos_last;

    // end of text restarts everything
    if (end_of_text) begin
      ina_nxt   = 1'b0;
      inq_nxt   = 1'b0;
      start_nxt = '0;
      has_nxt   = 1'b0;
      pos_nxt   = '0;
      ovf_nxt   = 1'b0;
    end

    start_ext  = {16'b0, start_r};
    len_ext    = {16'b0, len};
    ent.arg_v  = arg_v;
    ent.cmd_v  = cmd_v;
    ent.ovf    = ovf_r;
    ent.offset = start_ext[15:0];
    ent.length = len_ext[15:0];
    ent_push   = accept && (arg_v || cmd_v);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      start_r <= '0;
      ina_r   <= 1'b0;
      inq_r   <= 1'b0;
      has_r   <= 1'b0;
      ovf_r   <= 1'b0;
    end else if (accept) begin
      pos_r   <= pos_nxt;
      start_r <= start_nxt;
      ina_r   <= ina_nxt;
      inq_r   <= inq_nxt;
      has_r   <= has_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

endmodule

// ===== src/qct_queue.sv =====
// short record queue between front and back end
`include "quoted_command_tokenizer_defines.svh"

module qct_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  qct_pkg::entry_t wr_entry,
  input  logic            pop,
  output qct_pkg::entry_t rd_entry,
  output logic            full,
  output logic            empty
);

  qct_pkg::entry_t                      mem_r [qct_pkg::QUEUE_DEPTH];
  logic [qct_pkg::QUEUE_PTR_BITS-1:0]   head_r, tail_r;
  logic [qct_pkg::QUEUE_CNT_BITS-1:0]   count_r;

  assign full     = (count_r == qct_pkg::QUEUE_CNT_BITS'(qct_pkg::QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign rd_entry = mem_r[head_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[tail_r] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        tail_r <= tail_r + 1'b1;
      end
      if (pop) begin
        head_r <= head_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  `QCT_ASSERT_IMPL(a_no_push_full, clk, rst_n, push, !full)
  `QCT_ASSERT_IMPL(a_no_pop_empty, clk, rst_n, pop, !empty)
  `QCT_ASSERT_IMPL(a_count_range, clk, rst_n, 1'b1, count_r <= qct_pkg::QUEUE_CNT_BITS'(qct_pkg::QUEUE_DEPTH))

endmodule

// ===== src/qct_back.sv =====
// back end: splits queued records into single results for the output
`include "quoted_command_tokenizer_defines.svh"

module qct_back (
  input  logic            clk,
  input  logic            rst_n,
  input  qct_pkg::entry_t q_entry,
  input  logic            q_empty,
  output logic            q_pop,
  input  logic            pop,
  output logic            empty,
  output logic            record_kind,
  output logic [15:0]     arg_offset,
  output logic [15:0]     arg_length,
  output logic            position_overflow,
  output logic            last_of_run
);

  qct_pkg::entry_t cur_r;
  logic            cur_valid_r;
  logic            taken, done;

  assign empty             = !cur_valid_r;
  assign last_of_run       = !(cur_r.arg_v && cur_r.cmd_v);
  assign record_kind       = cur_r.arg_v ? qct_pkg::KIND_ARG : qct_pkg::KIND_CMD_END;
  assign arg_offset        = cur_r.arg_v ? cur_r.offset : 16'd0;
  assign arg_length        = cur_r.arg_v ? cur_r.length : 16'd0;
  assign position_overflow = cur_r.ovf;

  assign taken = pop && cur_valid_r;
  assign done  = taken && last_of_run;
  assign q_pop = !q_empty && (!cur_valid_r || done);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
    end else if (q_pop) begin
      cur_valid_r <= 1'b1;
      cur_r       <= q_entry;
    end else if (done) begin
      cur_valid_r <= 1'b0;
    end else if (taken) begin
      // argument delivered, command end still to go
      cur_r.arg_v <= 1'b0;
    end
  end

  `QCT_ASSERT_IMPL(a_held_has_request, clk, rst_n, cur_valid_r, cur_r.arg_v || cur_r.cmd_v)
  `QCT_ASSERT_NEXT(a_pair_second, clk, rst_n, taken && !last_of_run, !empty && record_kind == qct_pkg::KIND_CMD_END)

endmodule

// ===== src/quoted_command_tokenizer.sv =====
// top level of the quoted command tokenizer
// a request's results are written to the queue, then loaded into the back end's holding register for output
// throughput: one character per cycle while the queue is not full, one result popped per cycle while results wait
// a character giving two results is held in the back end's register for two pops
// a four-entry queue between front and back end absorbs output stalls
// reset: synchronous, active low, clears tokenizer state and queue
module quoted_command_tokenizer #(
  parameter int POSITION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_char_code,
  input  logic        in_end_of_text,
  output logic        empty,
  input  logic        pop,
  output logic        out_record_kind,
  output logic [15:0] out_arg_offset,
  output logic [15:0] out_arg_length,
  output logic        out_position_overflow,
  output logic        out_last_of_run
);

  qct_pkg::entry_t ent, head;
  logic            ent_push, q_pop, q_full, q_empty;

  assign full = q_full;

  qct_front #(.POSITION_BITS(POSITION_BITS)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .q_full      (q_full),
    .char_code   (in_char_code),
    .end_of_text (in_end_of_text),
    .ent_push    (ent_push),
    .ent         (ent)
  );

  qct_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (ent_push),
    .wr_entry (ent),
    .pop      (q_pop),
    .rd_entry (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  qct_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_entry           (head),
    .q_empty           (q_empty),
    .q_pop             (q_pop),
    .pop               (pop),
    .empty             (empty),
    .record_kind       (out_record_kind),
    .arg_offset        (out_arg_offset),
    .arg_length        (out_arg_length),
    .position_overflow (out_position_overflow),
    .last_of_run       (out_last_of_run)
  );

endmodule

// ===== bench/tb_quoted_command_tokenizer.sv =====
`timescale 1ns / 1ps
// self-checking bench for the quoted command tokenizer: directed table and random commands
module tb_quoted_command_tokenizer;

  localparam int POS_BITS = 16;
  localparam logic [POS_BITS-1:0] POS_LIMIT = '1;
  localparam int HOLD_CYCLES = 120;
  localparam int PHASE_REQUESTS = 200;

  typedef struct packed {
    logic        kind;
    logic [15:0] offset;
    logic [15:0] length;
    logic        ovf;
    logic        last;
  } record_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       eot;
    logic       typed;
    logic [1:0] n_typed;
    record_t    rec0;
    record_t    rec1;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic [7:0]  in_char_code = '0;
  logic        in_end_of_text = 1'b0;
  logic        pop = 1'b0;
  logic        full;
  logic        empty;
  logic        out_record_kind;
  logic [15:0] out_arg_offset;
  logic [15:0] out_arg_length;
  logic        out_position_overflow;
  logic        out_last_of_run;

  // tokenizer state as predicted
  logic [POS_BITS-1:0] tok_pos = '0;
  logic [POS_BITS-1:0] tok_start = '0;
  logic tok_in_arg = 1'b0;
  logic tok_in_quote = 1'b0;
  logic tok_has_args = 1'b0;
  logic tok_ovf = 1'b0;

  record_t pending_records[$];
  row_t    directed_rows[$];
  int      failures = 0;
  int      requests_sent = 0;
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;
  bit      hold_armed = 1'b0;
  bit      hold_done = 1'b0;
  int      hold_count = 0;

  quoted_command_tokenizer DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .push                 (push),
    .full                 (full),
    .in_char_code         (in_char_code),
    .in_end_of_text       (in_end_of_text),
    .empty                (empty),
    .pop                  (pop),
    .out_record_kind      (out_record_kind),
    .out_arg_offset       (out_arg_offset),
    .out_arg_length       (out_arg_length),
    .out_position_overflow(out_position_overflow),
    .out_last_of_run      (out_last_of_run)
  );

  always #4 clk = ~clk;

  function automatic record_t make_record(logic kind, logic [15:0] off, logic [15:0] len,
                                          logic ovf, logic last);
    return {kind, off, len, ovf, last};
  endfunction

  task automatic emit_record(input logic kind, input logic [15:0] off, input logic [15:0] len,
                             inout int n, inout record_t [1:0] found);
    found[n] = {kind, off, len, tok_ovf, 1'b0};
    n++;
  endtask

  task automatic end_command(inout int n, inout record_t [1:0] found);
    if (tok_has_args) begin
      emit_record(qct_pkg::KIND_CMD_END, 16'd0, 16'd0, n, found);
      tok_has_args = 1'b0;
    end
  endtask

  task automatic close_argument(inout int n, inout record_t [1:0] found);
    logic [POS_BITS-1:0] len;
    len = (tok_pos >= tok_start) ? tok_pos - tok_start : '0;
    if (len != '0) begin
      emit_record(qct_pkg::KIND_ARG, tok_start[15:0], len[15:0], n, found);
      tok_has_args = 1'b1;
    end
    tok_in_arg = 1'b0;
    tok_in_quote = 1'b0;
  endtask

  task automatic tokenize(input logic [7:0] code, input logic eot,
                          output int n, output record_t [1:0] found);
    logic [7:0] c;
    logic is_sep;
    logic is_end;
    logic done;
    n = 0;
    found = '0;
    c = eot ? qct_pkg::CH_NUL : code;
    is_sep = (c == qct_pkg::CH_SPACE) || (c == qct_pkg::CH_NUL);
    is_end = (c == qct_pkg::CH_SEMI) || (c == qct_pkg::CH_NEWLINE);
    done = 1'b0;
    if (!tok_in_arg) begin
      if (is_sep) begin
        done = 1'b1;
      end else if (is_end) begin
        end_command(n, found);
        done = 1'b1;
      end else begin
        tok_in_arg = 1'b1;
        tok_in_quote = 1'b0;
        tok_start = tok_pos;
      end
    end
    if (!done) begin
      if (!tok_in_quote) begin
        if (is_sep || is_end) begin
          close_argument(n, found);
          if (is_end) end_command(n, found);
        end else if (c == qct_pkg::CH_QUOTE) begin
          tok_in_quote = 1'b1;
          tok_start = (tok_pos < POS_LIMIT) ? tok_pos + 1'b1 : POS_LIMIT;
        end
      end else if (c == qct_pkg::CH_QUOTE || c == qct_pkg::CH_NUL) begin
        close_argument(n, found);
      end
    end
    if (eot) begin
      end_command(n, found);
      tok_pos = '0;
      tok_start = '0;
      tok_in_arg = 1'b0;
      tok_in_quote = 1'b0;
      tok_has_args = 1'b0;
      tok_ovf = 1'b0;
    end else if (tok_pos < POS_LIMIT) begin
      tok_pos = tok_pos + 1'b1;
    end else begin
      tok_ovf = 1'b1;
    end
    if (n > 0) found[n-1].last = 1'b1;
  endtask

  task automatic send_request(input logic [7:0] ch, input logic eot, input logic typed = 1'b0,
                              input int n_typed = 0, input record_t [1:0] typed_recs = '0);
    int n;
    int i;
    record_t [1:0] found;
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_char_code <= ch;
    in_end_of_text <= eot;
    @(posedge clk);
    while (full) @(posedge clk);
    tokenize(ch, eot, n, found);
    if (typed) begin
      n = n_typed;
      found = typed_recs;
    end
    for (i = 0; i < n; i++) pending_records.insert(pending_records.size(), found[i]);
    requests_sent++;
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk);
    while (pending_records.size() != 0) @(posedge clk);
  endtask

  task automatic add_row(input logic [7:0] ch, input logic eot, input logic typed,
                         input int n = 0, input record_t r0 = '0, input record_t r1 = '0);
    row_t row;
    row.ch = ch;
    row.eot = eot;
    row.typed = typed;
    row.n_typed = n[1:0];
    row.rec0 = r0;
    row.rec1 = r1;
    directed_rows.insert(directed_rows.size(), row);
  endtask

  function automatic logic [7:0] word_char();
    logic [7:0] c;
    c = 8'($urandom_range(255));
    while (c == qct_pkg::CH_SPACE || c == qct_pkg::CH_NUL || c == qct_pkg::CH_SEMI ||
           c == qct_pkg::CH_NEWLINE || c == qct_pkg::CH_QUOTE)
      c = 8'($urandom_range(255));
    return c;
  endfunction

  function automatic logic [7:0] quoted_char();
    logic [7:0] c;
    c = 8'($urandom_range(255));
    while (c == qct_pkg::CH_QUOTE || c == qct_pkg::CH_NUL) c = 8'($urandom_range(255));
    return c;
  endfunction

  task automatic send_word(input int len);
    int j;
    for (j = 0; j < len; j++) send_request(word_char(), 1'b0);
  endtask

  task automatic send_random_command();
    int nargs;
    int k;
    int j;
    int style;
    nargs = $urandom_range(4);
    for (k = 0; k < nargs; k++) begin
      style = $urandom_range(9);
      if (style < 6) begin
        send_word($urandom_range(1, 6));
      end else if (style < 8) begin
        send_request(qct_pkg::CH_QUOTE, 1'b0);
        for (j = 0; j < $urandom_range(6); j++) send_request(quoted_char(), 1'b0);
        send_request(($urandom_range(5) == 0) ? qct_pkg::CH_NUL : qct_pkg::CH_QUOTE, 1'b0);
      end else if (style == 8) begin
        // quote in the middle of a plain word
        send_word($urandom_range(1, 3));
        send_request(qct_pkg::CH_QUOTE, 1'b0);
        send_word($urandom_range(0, 3));
        send_request(qct_pkg::CH_QUOTE, 1'b0);
      end else begin
        // quote left open up to the end of the text
        send_request(qct_pkg::CH_QUOTE, 1'b0);
        for (j = 0; j < $urandom_range(4); j++) send_request(quoted_char(), 1'b0);
        send_request(8'($urandom_range(255)), 1'b1);
        return;
      end
      for (j = 0; j < $urandom_range(1, 2); j++)
        send_request(($urandom_range(5) == 0) ? qct_pkg::CH_NUL : qct_pkg::CH_SPACE, 1'b0);
    end
    style = $urandom_range(19);
    if (style < 9) begin
      send_request(qct_pkg::CH_SEMI, 1'b0);
    end else if (style < 18) begin
      send_request(qct_pkg::CH_NEWLINE, 1'b0);
    end else if (style == 18) begin
      send_request(8'($urandom_range(255)), 1'b1);
    end else begin
      for (j = 0; j < $urandom_range(1, 4); j++)
        send_request(8'($urandom_range(255)), ($urandom_range(7) == 0));
    end
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input bit hold);
    int target;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    if (hold) hold_armed = 1'b1;
    target = requests_sent + PHASE_REQUESTS;
    while (requests_sent < target) send_random_command();
    wait_drained();
  endtask

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endtask

  // receiver side, with one long hold-off while the sender keeps going
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (hold_armed && !hold_done) begin
      pop <= 1'b0;
      if (hold_count == HOLD_CYCLES) hold_done <= 1'b1;
      hold_count <= hold_count + 1;
    end else begin
      pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    record_t want;
    if (rst_n && pop && !empty) begin
      if (pending_records.size() == 0) begin
        $error("unexpected result: kind %0d offset %0d length %0d",
               out_record_kind, out_arg_offset, out_arg_length);
        failures++;
      end else begin
        want = pending_records.pop_front();
        check_field("record_kind", 16'(want.kind), 16'(out_record_kind));
        check_field("arg_offset", want.offset, out_arg_offset);
        check_field("arg_length", want.length, out_arg_length);
        check_field("position_overflow", 16'(want.ovf), 16'(out_position_overflow));
        check_field("last_of_run", 16'(want.last), 16'(out_last_of_run));
      end
    end
  end

  initial begin
    add_row(qct_pkg::CH_SEMI, 1'b0, 1'b1, 0);
    add_row(qct_pkg::CH_SPACE, 1'b0, 1'b1, 0);
    add_row(qct_pkg::CH_NUL, 1'b0, 1'b1, 0);
    add_row("a", 1'b0, 1'b1, 0);
    add_row(8'hFF, 1'b0, 1'b1, 0);
    add_row(qct_pkg::CH_SPACE, 1'b0, 1'b1, 1,
            make_record(qct_pkg::KIND_ARG, 16'd3, 16'd2, 1'b0, 1'b1));
    add_row(qct_pkg::CH_QUOTE, 1'b0, 1'b0);
    add_row(qct_pkg::CH_SEMI, 1'b0, 1'b0);
    add_row(qct_pkg::CH_SPACE, 1'b0, 1'b0);
    add_row(qct_pkg::CH_NEWLINE, 1'b0, 1'b0);
    add_row(qct_pkg::CH_QUOTE, 1'b0, 1'b0);
    add_row("x", 1'b0, 1'b0);
    add_row(qct_pkg::CH_QUOTE, 1'b0, 1'b0);
    add_row("y", 1'b0, 1'b0);
    add_row(qct_pkg::CH_NUL, 1'b0, 1'b0);
    add_row(qct_pkg::CH_NEWLINE, 1'b0, 1'b1, 1,
            make_record(qct_pkg::KIND_CMD_END, 16'd0, 16'd0, 1'b0, 1'b1));
    add_row("q", 1'b0, 1'b0);
    add_row(qct_pkg::CH_SEMI, 1'b0, 1'b0);
    add_row(qct_pkg::CH_QUOTE, 1'b0, 1'b0);
    add_row(qct_pkg::CH_QUOTE, 1'b0, 1'b0);
    add_row("z", 1'b0, 1'b0);
    add_row(qct_pkg::CH_QUOTE, 1'b0, 1'b0);
    add_row("w", 1'b0, 1'b0);
    add_row(8'hA5, 1'b1, 1'b0);
    add_row(qct_pkg::CH_SEMI, 1'b1, 1'b1, 0);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[k])
      send_request(directed_rows[k].ch, directed_rows[k].eot, directed_rows[k].typed,
                   directed_rows[k].n_typed, {directed_rows[k].rec1, directed_rows[k].rec0});
    wait_drained();

    run_phase(0, 0, 1'b1);
    run_phase(75, 0, 1'b0);
    run_phase(0, 75, 1'b0);
    run_phase(29, 29, 1'b0);

    wait_drained();
    repeat (16) @(posedge clk);
    if (failures == 0) $display("tb_quoted_command_tokenizer OK");
    else $display("tb_quoted_command_tokenizer NOT OK");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("tb_quoted_command_tokenizer NOT OK");
    $finish;
  end

endmodule
